[hdl/radix2_fft_frame_core_macros.svh]
// Assertion macros shared by the FFT frame core.
`ifndef RADIX2_FFT_FRAME_CORE_MACROS_SVH
`define RADIX2_FFT_FRAME_CORE_MACROS_SVH

// Property that must hold in the same cycle as its antecedent.
`define R2FFT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Property that must hold in the cycle after its antecedent.
`define R2FFT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/r2fft_pkg.sv]
// Shared types, register codes and twiddle table function of the FFT frame core.
package r2fft_pkg;

  localparam int WORD_W = 27;
  localparam int BIN_W  = 26;

  localparam logic REG_INVERSE_MODE = 1'b0;
  localparam logic REG_LOG2_POINTS  = 1'b1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam longint unsigned Q30_ONE     = 64'd1073741824;
  localparam longint unsigned Q30_HALF_PI = 64'd1686629713;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_RD_K = 8'b0000_0010,
    ST_RD_J = 8'b0000_0100,
    ST_MUL  = 8'b0000_1000,
    ST_ADD  = 8'b0001_0000,
    ST_WR_K = 8'b0010_0000,
    ST_WR_J = 8'b0100_0000,
    ST_BIN  = 8'b1000_0000
  } fft_state_t;

  // Divide a series term by (k+1)(k+2).
  function automatic longint unsigned term_div(longint unsigned term, int k);
    longint unsigned d;
    case (k)
      0: d = term / 2;     1: d = term / 6;     2: d = term / 12;    3: d = term / 20;
      4: d = term / 30;    5: d = term / 42;    6: d = term / 56;    7: d = term / 72;
      8: d = term / 90;    9: d = term / 110;   10: d = term / 132;  11: d = term / 156;
      12: d = term / 182;  13: d = term / 210;  14: d = term / 240;  15: d = term / 272;
      16: d = term / 306;  17: d = term / 342;  18: d = term / 380;  19: d = term / 420;
      20: d = term / 462;  21: d = term / 506;  22: d = term / 552;  23: d = term / 600;
      24: d = term / 650;  25: d = term / 702;  26: d = term / 756;  27: d = term / 812;
      28: d = term / 870;  29: d = term / 930;  30: d = term / 992;  31: d = term / 1056;
      32: d = term / 1122; 33: d = term / 1190; 34: d = term / 1260; 35: d = term / 1332;
      36: d = term / 1406; 37: d = term / 1482; 38: d = term / 1560;
      default: d = term / 1640;
    endcase
    return d;
  endfunction

  // Twiddle for angle 2*pi*m/2^lg: {cos, sin}, each 24-bit signed Q1.(tb-2).
  function automatic logic [47:0] tw_entry(int m, int lg, int tb);
    longint unsigned q, r, x, term;
    longint acc, s, c, cs, sn;
    int k, sh;
    bit neg;
    logic [1:0] quad;
    q = (64'(m) * 4) & ((64'd4 << lg) - 1);
    quad = 2'(q >> lg);
    r = q & ((64'd1 << lg) - 1);
    x = (Q30_HALF_PI * r) >> lg;
    sh = 30 - (tb - 2);
    acc = 0; term = x; neg = 1'b0;
    for (k = 1; k < 40; k += 2) begin
      if (term != 0) begin
        acc = neg ? acc - longint'(term) : acc + longint'(term);
        term = (((term * x) >> 30) * x) >> 30;
        term = term_div(term, k);
        neg = !neg;
      end
    end
    s = acc < 0 ? 0 : (acc > longint'(Q30_ONE) ? longint'(Q30_ONE) : acc);
    acc = 0; term = Q30_ONE; neg = 1'b0;
    for (k = 0; k < 40; k += 2) begin
      if (term != 0) begin
        acc = neg ? acc - longint'(term) : acc + longint'(term);
        term = (((term * x) >> 30) * x) >> 30;
        term = term_div(term, k);
        neg = !neg;
      end
    end
    c = acc < 0 ? 0 : (acc > longint'(Q30_ONE) ? longint'(Q30_ONE) : acc);
    s = (s + (longint'(1) << (sh - 1))) >>> sh;
    c = (c + (longint'(1) << (sh - 1))) >>> sh;
    case (quad)
      2'd0: begin cs = c;  sn = s;  end
      2'd1: begin cs = -s; sn = c;  end
      2'd2: begin cs = -c; sn = -s; end
      default: begin cs = s; sn = -c; end
    endcase
    return {cs[23:0], sn[23:0]};
  endfunction

endpackage

[hdl/radix2_fft_frame_core.sv]
// Framed radix-2 DIT FFT core with one shared complex butterfly unit.
//
//  channel  dir  handshake          payload
//  s_       in   s_tvalid/s_tready  s_tdata {im, re}, s_tuser op
//  m_       out  m_tvalid/m_tready  m_tdata {index, im, re}, m_tuser valid, m_tlast
//  cfg_     in   cfg_we             cfg_index, cfg_data
//
// The last load of a frame starts the transform: one multiplier does the four products
// of each butterfly, and the work memory is read twice and written twice per butterfly.
// A read goes through the memory read and then the output register; with no frame held,
// an empty beat goes straight into the output register.
// Input is not taken while the output register holds an untaken beat.
// Reset is synchronous; the work memory is not cleared and needs no clearing pass.
`include "radix2_fft_frame_core_macros.svh"

module radix2_fft_frame_core
  import r2fft_pkg::*;
#(
  parameter int MAX_POINTS   = 1024,
  parameter int SAMPLE_BITS  = 16,
  parameter int TWIDDLE_BITS = 18
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // [SAMPLE_BITS-1:0] sample_re, [2*SAMPLE_BITS-1:SAMPLE_BITS] sample_im
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
  // [0] op
  input  logic s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // [25:0] bin_re, [51:26] bin_im, [51+log2(MAX_POINTS):52] bin_index
  output logic [((2*26+$clog2(MAX_POINTS)+7)/8)*8-1:0] m_tdata,
  // [0] bin_valid
  output logic m_tuser,
  output logic m_tlast,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [3:0] cfg_data
);

  localparam int LMAX     = $clog2(MAX_POINTS);
  localparam int TW_AW    = (LMAX > 1) ? LMAX - 1 : 1;
  localparam int TW_DEPTH = MAX_POINTS / 2;
  localparam int FB       = TWIDDLE_BITS - 2;
  localparam int PW       = TWIDDLE_BITS + WORD_W;
  localparam int AW       = PW + 1;
  localparam int SW       = AW + 1;
  localparam int OUT_W    = ((2*BIN_W + LMAX + 7) / 8) * 8;

  fft_state_t state;

  logic             inverse_mode;
  logic [3:0]       log2_points;
  logic [LMAX-1:0]  load_count;
  logic [LMAX-1:0]  read_count;
  logic             frame_ready;

  logic [3:0]       l_eff;
  logic [LMAX-1:0]  pt_mask;
  logic [LMAX-1:0]  half_last;

  // Work memory, one word {im, re}.
  logic [2*WORD_W-1:0] work_mem [MAX_POINTS];
  logic [2*WORD_W-1:0] rdata;
  logic [2*WORD_W-1:0] wdata;
  logic [LMAX-1:0]     raddr;
  logic [LMAX-1:0]     waddr;
  logic                we;

  // Twiddle table.
  logic [47:0]      tw_rom [TW_DEPTH];
  logic [47:0]      tw_q;
  logic [TW_AW-1:0] tw_addr;

  // Butterfly sequencer and datapath.
  logic [3:0]       sidx;
  logic [LMAX-1:0]  bf;
  logic [1:0]       step;
  logic [LMAX-1:0]  low_mask;
  logic [LMAX-1:0]  j_addr;
  logic [LMAX-1:0]  k_addr;
  logic [LMAX-1:0]  m_full;
  logic signed [WORD_W-1:0] xk_re, xk_im, xj_re, xj_im;
  logic signed [TWIDDLE_BITS-1:0] w_re, w_im, mul_a;
  logic signed [WORD_W-1:0] mul_b;
  logic signed [PW-1:0] prod;
  logic signed [AW-1:0] acc_re, acc_im;
  logic signed [AW-1:0] t_re, t_im;

  // Load path.
  logic [LMAX-1:0]  ld_idx;
  logic [LMAX-1:0]  rev_full;
  logic [LMAX-1:0]  rev;
  logic [WORD_W-1:0] ld_re, ld_im;
  logic [LMAX-1:0]  rd_idx;
  logic [LMAX-1:0]  bin_idx;

  // Output path.
  logic signed [WORD_W:0]  sc_re, sc_im;
  logic signed [BIN_W-1:0] bin_re, bin_im;
  logic [BIN_W-1:0]        out_re, out_im;
  logic [LMAX-1:0]         out_idx;

  logic in_acc;
  logic empty_rd;

  function automatic logic [WORD_W-1:0] sat_word(logic signed [SW-1:0] v);
    logic signed [SW-1:0] hi, lo;
    hi = SW'((64'sd1 <<< (WORD_W - 1)) - 1);
    lo = -hi - SW'(1);
    if (v > hi) return hi[WORD_W-1:0];
    if (v < lo) return lo[WORD_W-1:0];
    return v[WORD_W-1:0];
  endfunction

  function automatic logic [BIN_W-1:0] sat_bin(logic signed [WORD_W:0] v);
    logic signed [WORD_W:0] hi, lo;
    hi = (WORD_W+1)'((64'sd1 <<< (BIN_W - 1)) - 1);
    lo = -hi - (WORD_W+1)'(1);
    if (v > hi) return hi[BIN_W-1:0];
    if (v < lo) return lo[BIN_W-1:0];
    return v[BIN_W-1:0];
  endfunction

  genvar g;
  generate
    for (g = 0; g < TW_DEPTH; g++) begin : g_tw
      assign tw_rom[g] = tw_entry(g, LMAX, TWIDDLE_BITS);
    end
  endgenerate

  always_comb begin
    if (log2_points == 4'd0) l_eff = 4'd1;
    else if (log2_points > 4'(LMAX)) l_eff = 4'(LMAX);
    else l_eff = log2_points;
  end

  assign pt_mask   = LMAX'((1 << l_eff) - 1);
  assign half_last = LMAX'((1 << (l_eff - 4'd1)) - 1);

  assign s_tready = (state == ST_IDLE) && (!m_tvalid || m_tready);
  assign in_acc   = s_tvalid && s_tready;
  assign empty_rd = (state == ST_IDLE) && in_acc && (s_tuser == OP_READ) && !frame_ready;

  // Butterfly addressing: j has a zero inserted at bit sidx of bf.
  assign low_mask = LMAX'((1 << sidx) - 1);
  assign j_addr   = ((bf & ~low_mask) << 1) | (bf & low_mask);
  assign k_addr   = j_addr | (low_mask + LMAX'(1));
  assign m_full   = (bf & low_mask) << (4'(LMAX - 1) - sidx);
  assign tw_addr  = TW_AW'(m_full);

  assign w_re = tw_q[24+TWIDDLE_BITS-1:24];
  assign w_im = inverse_mode ? -$signed(tw_q[TWIDDLE_BITS-1:0])
                             : $signed(tw_q[TWIDDLE_BITS-1:0]);

  always_comb begin
    case (step)
      2'd0: begin mul_a = w_re; mul_b = xk_re; end
      2'd1: begin mul_a = w_im; mul_b = xk_im; end
      2'd2: begin mul_a = w_re; mul_b = xk_im; end
      default: begin mul_a = w_im; mul_b = xk_re; end
    endcase
  end

  assign t_re = (acc_re + AW'(1 <<< (FB - 1))) >>> FB;
  assign t_im = (acc_im + AW'(1 <<< (FB - 1))) >>> FB;

  // Bit-reversed load position.
  assign ld_idx = frame_ready ? '0 : (load_count & pt_mask);
  always_comb begin
    for (int t = 0; t < LMAX; t++) begin
      rev_full[t] = ld_idx[LMAX-1-t];
    end
  end
  assign rev   = rev_full >> (4'(LMAX) - l_eff);
  assign ld_re = {{(WORD_W-SAMPLE_BITS){s_tdata[SAMPLE_BITS-1]}}, s_tdata[SAMPLE_BITS-1:0]};
  assign ld_im = {{(WORD_W-SAMPLE_BITS){s_tdata[2*SAMPLE_BITS-1]}},
                  s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]};
  assign rd_idx = read_count & pt_mask;

  always_comb begin
    we    = 1'b0;
    waddr = rev;
    wdata = {ld_im, ld_re};
    raddr = k_addr;
    case (state)
      ST_IDLE: begin
        raddr = rd_idx;
        we    = in_acc && (s_tuser == OP_LOAD);
      end
      ST_RD_J: raddr = j_addr;
      ST_WR_K: begin
        we    = 1'b1;
        waddr = k_addr;
        wdata = {sat_word(SW'(xj_im) - SW'(t_im)), sat_word(SW'(xj_re) - SW'(t_re))};
      end
      ST_WR_J: begin
        we    = 1'b1;
        waddr = j_addr;
        wdata = {sat_word(SW'(xj_im) + SW'(t_im)), sat_word(SW'(xj_re) + SW'(t_re))};
      end
      default: raddr = k_addr;
    endcase
  end

  always_ff @(posedge clk) begin
    rdata <= work_mem[raddr];
    if (we) begin
      work_mem[waddr] <= wdata;
    end
  end

  // Inverse scaling by a rounded shift, then clip to the bin width.
  always_comb begin
    sc_re = (WORD_W+1)'($signed(rdata[WORD_W-1:0]));
    sc_im = (WORD_W+1)'($signed(rdata[2*WORD_W-1:WORD_W]));
    if (inverse_mode) begin
      sc_re = (sc_re + ((WORD_W+1)'(1) <<< (l_eff - 4'd1))) >>> l_eff;
      sc_im = (sc_im + ((WORD_W+1)'(1) <<< (l_eff - 4'd1))) >>> l_eff;
    end
  end
  assign bin_re = sat_bin(sc_re);
  assign bin_im = sat_bin(sc_im);

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state == ST_RD_K) tw_q <= tw_rom[tw_addr];
    if (state == ST_RD_J) begin
      xk_re <= rdata[WORD_W-1:0];
      xk_im <= rdata[2*WORD_W-1:WORD_W];
    end
    if (state == ST_MUL && step == 2'd0) begin
      xj_re <= rdata[WORD_W-1:0];
      xj_im <= rdata[2*WORD_W-1:WORD_W];
    end
    prod <= mul_a * mul_b;
    if (state == ST_MUL) begin
      case (step)
        2'd1: acc_re <= AW'(prod);
        2'd2: acc_re <= acc_re - AW'(prod);
        2'd3: acc_im <= AW'(prod);
        default: acc_im <= acc_im;
      endcase
    end
    if (state == ST_ADD) acc_im <= acc_im + AW'(prod);
    if (in_acc) bin_idx <= rd_idx;
  end

  // Control.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      inverse_mode <= 1'b0;
      log2_points  <= 4'd10;
      load_count   <= '0;
      read_count   <= '0;
      frame_ready  <= 1'b0;
      sidx         <= '0;
      bf           <= '0;
      step         <= '0;
      m_tvalid     <= 1'b0;
      m_tuser      <= 1'b0;
      m_tlast      <= 1'b0;
      out_re       <= '0;
      out_im       <= '0;
      out_idx      <= '0;
    end else begin
      if (m_tvalid && m_tready && !empty_rd) m_tvalid <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == REG_INVERSE_MODE) begin
          inverse_mode <= cfg_data[0];
        end else begin
          log2_points <= cfg_data;
          load_count  <= '0;
          read_count  <= '0;
          frame_ready <= 1'b0;
        end
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (s_tuser == OP_LOAD) begin
              frame_ready <= 1'b0;
              read_count  <= '0;
              if (ld_idx == pt_mask) begin
                load_count <= '0;
                sidx       <= '0;
                bf         <= '0;
                state      <= ST_RD_K;
              end else begin
                load_count <= ld_idx + LMAX'(1);
              end
            end else if (frame_ready) begin
              state <= ST_BIN;
            end else begin
              // nothing held: answer at once with an empty beat
              m_tvalid <= 1'b1;
              m_tuser  <= 1'b0;
              m_tlast  <= 1'b0;
              out_re   <= '0;
              out_im   <= '0;
              out_idx  <= '0;
            end
          end
        end
        ST_RD_K: state <= ST_RD_J;
        ST_RD_J: begin
          step  <= '0;
          state <= ST_MUL;
        end
        ST_MUL: begin
          step <= step + 2'd1;
          if (step == 2'd3) state <= ST_ADD;
        end
        ST_ADD:  state <= ST_WR_K;
        ST_WR_K: state <= ST_WR_J;
        ST_WR_J: begin
          if (bf == half_last) begin
            bf <= '0;
            if (sidx == l_eff - 4'd1) begin
              frame_ready <= 1'b1;
              state       <= ST_IDLE;
            end else begin
              sidx  <= sidx + 4'd1;
              state <= ST_RD_K;
            end
          end else begin
            bf    <= bf + LMAX'(1);
            state <= ST_RD_K;
          end
        end
        ST_BIN: begin
          m_tvalid <= 1'b1;
          m_tuser  <= 1'b1;
          m_tlast  <= (bin_idx == pt_mask);
          out_re   <= bin_re;
          out_im   <= bin_im;
          out_idx  <= bin_idx;
          if (bin_idx == pt_mask) begin
            frame_ready <= 1'b0;
            read_count  <= '0;
          end else begin
            read_count <= bin_idx + LMAX'(1);
          end
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tdata = OUT_W'({out_idx, out_im, out_re});

  `R2FFT_ASSERT_NOW(a_no_held_frame_in_run, state == ST_RD_K, !frame_ready, "transform running with a held frame")
  `R2FFT_ASSERT_NOW(a_stage_in_range, state == ST_RD_K, sidx < l_eff, "stage index beyond transform length")
  `R2FFT_ASSERT_NEXT(a_bin_delivered, state == ST_BIN, m_tvalid && m_tuser && state == ST_IDLE, "bin read did not reach the output")

endmodule
